/* sv/rita_pkg.sv */
package rita_pkg;

  localparam int BASE_MIN      = 2;
  localparam int BASE_MAX      = 36;
  localparam logic [5:0] BASE_RESET = 6'd16;

  // quotient bits resolved per divider cycle
  localparam int BITS_PER_STEP = 4;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h61;
  localparam logic [5:0] DEC_DIGITS = 6'd10;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_READ  = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;       // take a new value, clear counters
    logic div_step;   // one divider step
    logic digit_wr;   // store remainder as next digit
    logic rd_issue;   // read next digit, most significant first
    logic out_load;   // move read digit into output register
  } cmd_t;

  typedef struct packed {
    logic step_last;  // current divider cycle is the final one
    logic quot_zero;  // quotient exhausted
    logic final_digit;// digit in read register is the least significant
    logic out_free;   // output register can take a beat
  } status_t;

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    logic [6:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A + {1'b0, d - DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

/* sv/rita_ctrl.sv */
module rita_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rita_pkg::status_t status,
  output rita_pkg::cmd_t    cmd
);
  import rita_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.digit_wr = 1'b1;
        state_next   = status.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = status.final_digit ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/rita_dp.sv */
module rita_dp #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [5:0]             base,
  input  rita_pkg::cmd_t         cmd,
  output rita_pkg::status_t      status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             digit_char,
  output logic                   last
);
  import rita_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int QW    = STEPS * BITS_PER_STEP;
  localparam int SW    = $clog2(STEPS);
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int CW    = $clog2(VALUE_WIDTH + 1);

  logic [QW-1:0] quot;
  logic [5:0]    rem;
  logic [SW-1:0] step;
  logic [CW-1:0] cnt;
  logic [5:0]    rdata;
  logic          rd_final;

  logic [QW-1:0] quot_step;
  logic [5:0]    rem_step;
  logic [6:0]    trial;
  logic [AW-1:0] rd_idx;

  logic [5:0]    mem [VALUE_WIDTH];

  // restoring division, a few quotient bits per cycle
  always_comb begin
    quot_step = quot;
    rem_step  = rem;
    trial     = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial     = {rem_step, quot_step[QW-1]};
      quot_step = {quot_step[QW-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial        = trial - {1'b0, base};
        quot_step[0] = 1'b1;
      end
      rem_step = trial[5:0];
    end
  end

  assign rd_idx = AW'(cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot <= QW'(value);
      rem  <= '0;
      step <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      quot <= quot_step;
      rem  <= rem_step;
      step <= step + 1'b1;
    end else if (cmd.digit_wr) begin
      rem  <= '0;
      step <= '0;
      cnt  <= cnt + 1'b1;
    end else if (cmd.rd_issue) begin
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_wr) begin
      mem[cnt[AW-1:0]] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata    <= mem[rd_idx];
      rd_final <= (cnt == CW'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digit_char <= digit_to_ascii(rdata);
      last       <= rd_final;
    end
  end

  assign status.step_last   = (step == SW'(STEPS - 1));
  assign status.quot_zero   = (quot == '0);
  assign status.final_digit = rd_final;
  assign status.out_free    = !out_valid || !out_stall;

endmodule

/* sv/radix_integer_to_ascii.sv */
// Channel  | handshake              | payload
// ---------+------------------------+----------------------------------
// input    | in_valid / in_stall    | value[VALUE_WIDTH-1:0]
// output   | out_valid / out_stall  | digit_char[6:0], last
// config   | cfg_write              | cfg_data[5:0] (radix, kept in 2..36)
//
// Each digit costs ceil(VALUE_WIDTH/4) divider steps (4 quotient bits per
// cycle) plus a store into the digit memory; digits are then replayed from
// the digit memory, each beat a read and then a load into the output
// register, the load waiting while the output register is held by a stall.
// Synchronous active-high reset; radix resets to 16.
// out_stall only holds up the replay; the next value is taken while the
// final beat still sits in the output register.
module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [5:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             digit_char,
  output logic                   last
);
  import rita_pkg::*;

  logic [5:0] base;
  cmd_t       cmd;
  status_t    status;

  // radix register, saturating writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_write) begin
      priority if (cfg_data < 6'(BASE_MIN)) begin
        base <= 6'(BASE_MIN);
      end else if (cfg_data > 6'(BASE_MAX)) begin
        base <= 6'(BASE_MAX);
      end else begin
        base <= cfg_data;
      end
    end
  end

  // sequencer: divide, store digits LSB first, replay MSB first
  rita_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // divider, digit memory and output register
  rita_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .base       (base),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a beat and did not go busy");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (base >= 6'(BASE_MIN)) && (base <= 6'(BASE_MAX)))
    else $error("radix register out of range");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) ||
                   (digit_char >= 7'h61 && digit_char <= 7'h7a)))
    else $error("digit character out of range");
`endif

endmodule

/* test/radix_integer_to_ascii_tb.sv */
`timescale 1ns / 100ps

module radix_integer_to_ascii_tb;

  import rita_pkg::BASE_MIN;
  import rita_pkg::BASE_MAX;
  import rita_pkg::BASE_RESET;

  localparam int VALUE_WIDTH = 64;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

  // ASCII anchors for the digit alphabet: '0'..'9' then 'a'..'z'
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [5:0] DECIMAL    = 6'd10;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  // one output beat as the block should produce it
  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } digit_beat_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [5:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [VALUE_WIDTH-1:0] value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [6:0]             digit_char;
  logic                   last;

  // shadow of the radix register, tracked through the same clamp as the block
  logic [5:0]  radix_model = BASE_RESET;
  // digits still owed by the block, oldest first
  digit_beat_t pending_digits[$];
  int          mismatch_count = 0;
  // set for phases that run both channels flat out
  bit          idle_off = 1'b0;

  radix_integer_to_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop. Slowest legal run: ~125 values, each 64 digits in base 2,
  // every beat held by the longest output stall: about 1.2 ms. This allows
  // several times that.
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 16);
  endfunction

  function automatic logic [6:0] ascii_of(input logic [5:0] d);
    if (d < DECIMAL) begin
      return CH_ZERO + 7'(d);
    end
    return CH_LOWER_A + 7'(d - DECIMAL);
  endfunction

  // Expand one value into its digits, most significant first, and queue
  // them. Remainders come out least significant first, so they are staged
  // and replayed backwards; zero is the lone '0'.
  function automatic void predict_digits(input logic [63:0] raw);
    logic [63:0] n;
    logic [5:0]  rems [0:63];
    int          cnt;
    n = raw & VALUE_MASK;
    cnt = 0;
    if (n == 0) begin
      pending_digits.push_back(digit_beat_t'{CH_ZERO, 1'b1});
      return;
    end
    while (n != 0) begin
      rems[cnt] = 6'(n % radix_model);
      n = n / radix_model;
      cnt++;
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      pending_digits.push_back(digit_beat_t'{ascii_of(rems[k]), k == 0});
    end
  endfunction

  // Value bit length drawn at random so every digit count shows up; a few
  // all-ones and zero values keep the extremes in the mix.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          width;
    int          roll;
    v = {$urandom, $urandom};
    width = $urandom_range(1, 64);
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return ALL_ONES;
    end else if (roll == 1) begin
      return '0;
    end
    if (width < 64) begin
      v = v & ((64'd1 << width) - 64'd1);
    end
    return v;
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  // Radix write. Only called with the block idle; the shadow clamps the
  // same way the register does.
  task automatic write_radix(input logic [5:0] r);
    cfg_write <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (r < BASE_MIN) begin
      radix_model = BASE_MIN;
    end else if (r > BASE_MAX) begin
      radix_model = BASE_MAX;
    end else begin
      radix_model = r;
    end
  endtask

  // Offer one value and hold it until the block takes it. Valid is left
  // high on return so a back-to-back value needs just one assignment; a
  // gap or the drain lowers it.
  task automatic send_value(input logic [63:0] v);
    int gap;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    predict_digits(v);
  endtask

  // Every value yields at least one digit, so an empty queue means idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // Out of reset the radix is 16: zero, single digits, the first carry and
  // the full-width extremes.
  task automatic test_reset_radix();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd15);
    send_value(64'd16);
    send_value(ALL_ONES);
    send_value(TOP_BIT);
    wait_drained();
  endtask

  // Writes outside 2..36 clamp. Base 2 on all ones gives the longest run,
  // 64 beats.
  task automatic test_radix_clamp();
    write_radix(6'd0);
    send_value(ALL_ONES);
    send_value(64'd5);
    wait_drained();
    write_radix(6'd1);
    send_value(64'd2);
    wait_drained();
    write_radix(6'd63);
    send_value(64'd35);
    send_value(64'd36);
    wait_drained();
    write_radix(6'd37);
    send_value(ALL_ONES);
    wait_drained();
  endtask

  // Digit/letter boundary in base 36, then plain decimal.
  task automatic test_letter_digits();
    write_radix(6'd36);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd35);
    send_value(64'd36);
    wait_drained();
    write_radix(6'd10);
    send_value(ALL_ONES);
    send_value(64'd1000);
    send_value(64'd0);
    wait_drained();
  endtask

  // Random radix per phase (first and last pinned to the range ends),
  // random values; every third phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [5:0] r;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        r = 6'd2;
      end else if (phase == 7) begin
        r = 6'd36;
      end else begin
        r = 6'($urandom_range(0, 63));
      end
      write_radix(r);
      idle_off = (phase % 3 == 1);
      repeat (13) send_value(rand_value());
      wait_drained();
    end
    idle_off = 1'b0;
  endtask

  // Output stall: short free runs, then a stall of random length unless
  // the phase asks for full speed.
  initial begin
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!idle_off && !rst) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted beat is checked against the oldest owed digit.
  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        log_mismatch($sformatf("beat with nothing owed: digit_char=%h last=%b",
                               digit_char, last));
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.ch || last !== want.fin) begin
          log_mismatch($sformatf("digit_char exp %h got %h, last exp %b got %b",
                                 want.ch, digit_char, want.fin, last));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_radix();
    test_radix_clamp();
    test_letter_digits();
    test_random_traffic();
    wait_drained();
    // give a full replay's worth of time for stray beats
    repeat (160) @(posedge clk);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
